>>> hdl/iop_pkg.sv
// Package: payload structs, action codes and width constants for the interval overlap query.
`timescale 1ns / 1ps

package iop_pkg;

    localparam int DATA_W       = 31;
    localparam int MARGIN_W     = 24;
    localparam int ACTION_W     = 2;
    // signed width for widened bounds, overlap and doubled overlap
    localparam int SW           = 35;
    localparam int RESULT_LIMIT = 64;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 24'd1000;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    typedef logic signed [SW-1:0] wide_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   range_start;
        logic [DATA_W-1:0]   range_end;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] match_start;
        logic [DATA_W-1:0] match_end;
        logic              found;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic below_lo;
        logic above_hi;
        logic hit;
    } eval_t;

endpackage

>>> hdl/iop_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module iop_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/iop_eval.sv
// Shared compare unit: bound checks and half-overlap test for one stored entry.
`timescale 1ns / 1ps

module iop_eval
    import iop_pkg::*;
(
    input  logic [DATA_W-1:0] entry_start,
    input  logic [DATA_W-1:0] entry_end,
    input  wide_t             lo,
    input  wide_t             hi,
    input  wide_t             rlen,
    output eval_t             result
);

    wide_t s_w;
    wide_t e_w;
    wide_t os;
    wide_t oe;
    wide_t ov;
    wide_t ov_clip;
    wide_t ov_dbl;
    wide_t elen;

    always_comb begin
        s_w     = $signed({{(SW-DATA_W){1'b0}}, entry_start});
        e_w     = $signed({{(SW-DATA_W){1'b0}}, entry_end});
        os      = (s_w > lo) ? s_w : lo;
        oe      = (e_w < hi) ? e_w : hi;
        ov      = oe - os;
        ov_clip = ov[SW-1] ? '0 : ov;
        ov_dbl  = ov_clip <<< 1;
        elen    = e_w - s_w;

        result.below_lo = s_w < lo;
        result.above_hi = s_w > hi;
        result.hit      = (ov_dbl >= elen) || (ov_dbl >= rlen);
    end

endmodule

>>> hdl/interval_overlap_query.sv
// Top level: interval table with append, clear and widened half-overlap query.
`timescale 1ns / 1ps
// Clear and append finish in the accept cycle; the block is ready again on the next cycle.
// A query runs a binary search (a read state and a compare state per step, ceil(log2(entries+1))
// steps), then scans the entries in order and ends in a flush state. A match is held in the scan,
// while one is already pending, and the flush waits, as long as the output register is stalled.
// Both search and scan go through the single read port of the table RAM.
// Reset (aresetn low, synchronous) empties the table and sets margin to 1000; table
// contents are undefined until written.

module interval_overlap_query
    import iop_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MARGIN_W-1:0] cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,

    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = 2 * DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCMP,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                state_reg,      state_next;
    logic [MARGIN_W-1:0]   margin_reg,     margin_next;
    logic [CW-1:0]         count_reg,      count_next;
    logic [DATA_W-1:0]     last_start_reg, last_start_next;
    wide_t                 lo_reg,         lo_next;
    wide_t                 hi_reg,         hi_next;
    wide_t                 rlen_reg,       rlen_next;
    logic [CW-1:0]         lb_reg,         lb_next;   // search lower bound
    logic [CW-1:0]         ub_reg,         ub_next;   // search upper bound
    logic [CW-1:0]         mid_reg,        mid_next;
    logic [CW-1:0]         idx_reg,        idx_next;
    logic [RES_CNT_W-1:0]  n_reg,          n_next;    // matches taken so far
    logic                  pend_valid_reg, pend_valid_next;
    logic [DATA_W-1:0]     pend_start_reg, pend_start_next;
    logic [DATA_W-1:0]     pend_end_reg,   pend_end_next;
    logic                  m_valid_reg,    m_valid_next;
    out_item_t             m_data_reg,     m_data_next;

    // table RAM, one entry = {start, end}
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    logic [DATA_W-1:0] rd_start;
    logic [DATA_W-1:0] rd_end;
    eval_t             ev;

    logic          out_free;
    logic          out_push;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_calc;
    logic [CW-1:0] idx_inc;
    logic          scan_done;

    iop_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[RW-1:DATA_W];
    assign rd_end   = ram_rdata[DATA_W-1:0];

    iop_eval u_eval (
        .entry_start (rd_start),
        .entry_end   (rd_end),
        .lo          (lo_reg),
        .hi          (hi_reg),
        .rlen        (rlen_reg),
        .result      (ev)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // output register slot is free when empty or being drained this cycle
    assign out_free  = !m_valid_reg || m_ready;

    assign mid_sum   = {1'b0, lb_reg} + {1'b0, ub_reg};
    assign mid_calc  = mid_sum[CW:1];
    assign idx_inc   = idx_reg + CW'(1);
    // end of scan: table exhausted, start past widened end, or result limit hit
    assign scan_done = (idx_reg == count_reg) || ev.above_hi
                       || (n_reg == RES_CNT_W'(RESULT_LIMIT));

    always_comb begin
        state_next      = state_reg;
        margin_next     = margin_reg;
        count_next      = count_reg;
        last_start_next = last_start_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        rlen_next       = rlen_reg;
        lb_next         = lb_reg;
        ub_next         = ub_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        m_data_next     = m_data_reg;
        out_push        = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {s_data.range_start, s_data.range_end};
        ram_raddr = idx_reg[AW-1:0];

        if (cfg_valid && cfg_ready) begin
            margin_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.action)
                        ACT_CLEAR: begin
                            count_next = '0;
                        end
                        ACT_APPEND: begin
                            // full table or out-of-order start: ignored
                            if (count_reg < CW'(TABLE_DEPTH) &&
                                (count_reg == '0 || s_data.range_start >= last_start_reg)) begin
                                ram_we          = 1'b1;
                                count_next      = count_reg + CW'(1);
                                last_start_next = s_data.range_start;
                            end
                        end
                        ACT_QUERY: begin
                            lo_next   = $signed({{(SW-DATA_W){1'b0}}, s_data.range_start})
                                      - $signed({{(SW-MARGIN_W){1'b0}}, margin_reg});
                            hi_next   = $signed({{(SW-DATA_W){1'b0}}, s_data.range_end})
                                      + $signed({{(SW-MARGIN_W){1'b0}}, margin_reg});
                            rlen_next = $signed({{(SW-DATA_W){1'b0}}, s_data.range_end})
                                      - $signed({{(SW-DATA_W){1'b0}}, s_data.range_start});
                            lb_next         = '0;
                            ub_next         = count_reg;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                if (lb_reg == ub_reg) begin
                    // first entry with start >= lo found; fetch it for the scan
                    ram_raddr  = lb_reg[AW-1:0];
                    idx_next   = lb_reg;
                    state_next = ST_SCAN;
                end else begin
                    ram_raddr  = mid_calc[AW-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_SCMP;
                end
            end

            ST_SCMP: begin
                if (ev.below_lo) begin
                    lb_next = mid_reg + CW'(1);
                end else begin
                    ub_next = mid_reg;
                end
                state_next = ST_SEARCH;
            end

            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_FLUSH;
                end else if (ev.hit) begin
                    if (pend_valid_reg && !out_free) begin
                        ram_raddr = idx_reg[AW-1:0];    // stall, re-read same entry
                    end else begin
                        if (pend_valid_reg) begin
                            out_push    = 1'b1;
                            m_data_next = '{match_start: pend_start_reg,
                                            match_end:   pend_end_reg,
                                            found:       1'b1,
                                            last:        1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_start_next = rd_start;
                        pend_end_next   = rd_end;
                        n_next          = n_reg + RES_CNT_W'(1);
                        idx_next        = idx_inc;
                        ram_raddr       = idx_inc[AW-1:0];
                    end
                end else begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[AW-1:0];
                end
            end

            ST_FLUSH: begin
                if (out_free) begin
                    out_push = 1'b1;
                    if (pend_valid_reg) begin
                        m_data_next = '{match_start: pend_start_reg,
                                        match_end:   pend_end_reg,
                                        found:       1'b1,
                                        last:        1'b1};
                    end else begin
                        // no match: single empty result
                        m_data_next = '{match_start: '0, match_end: '0,
                                        found: 1'b0, last: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            margin_reg     <= MARGIN_RESET;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            n_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            margin_reg     <= margin_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            n_reg          <= n_next;
        end
        last_start_reg <= last_start_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        rlen_reg       <= rlen_next;
        lb_reg         <= lb_next;
        ub_reg         <= ub_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        m_data_reg     <= m_data_next;
    end

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a result is only loaded when the output register can take it
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> (!m_valid_reg || m_ready))
        else $error("result overwritten in output register");

    // scan index never passes the entry count
    a_scan_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= count_reg))
        else $error("scan index beyond entry count");

    // no held match survives into idle
    a_idle_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending match left in idle");

    // match count stays within the result limit
    a_res_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= RES_CNT_W'(RESULT_LIMIT))
        else $error("result count beyond limit");

endmodule
